### design/focsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FOC transform / SVPWM package
// Shared constants, the stage control struct and the fixed-point helpers.
// ----------------------------------------------------------------------------
package focsv_pkg;

    // Default number of entries in the full-wave sine table
    localparam int unsigned C_SINE_ENTRIES = 1024;

    // Clarke and SVPWM coefficients in Q0.16, sign-extended for signed products
    localparam logic signed [17:0] C_K_THIRD       = 18'sd21845;
    localparam logic signed [17:0] C_K_INV_SQRT3   = 18'sd37837;
    localparam logic signed [17:0] C_K_SQRT3_HALF  = 18'sd56756;

    // Table build: pi/2 in Q30 and the Taylor term divisors (2n)(2n+1)
    localparam logic [63:0]  C_HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned  C_TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    // Duty mid-point in Q0.16
    localparam logic signed [39:0] C_DUTY_MID = 40'sd32768;

    // Control travelling alongside each stage of payload
    typedef struct packed {
        logic vld;
        logic tag;
    } t_ctl;

    // Divide by 2^n, round to nearest, halves away from zero
    function automatic logic signed [39:0] f_rnd(input logic signed [39:0] v,
                                                 input int unsigned n);
        logic signed [39:0] half;
        logic signed [39:0] neg;
        half = 40'sd1 <<< (n - 1);
        neg  = $signed({39'd0, v[39]});
        f_rnd = (v + half - neg) >>> n;
    endfunction

    // Saturate to signed 16 bits
    function automatic logic signed [15:0] f_sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) begin
            f_sat16 = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            f_sat16 = 16'sh8000;
        end else begin
            f_sat16 = v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

### design/focsv_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sine table ROM
// Full-wave Q1.15 sine table built at elaboration, two registered read ports.
// ----------------------------------------------------------------------------
module focsv_sine_rom #(
    parameter int unsigned SINE_ENTRIES = focsv_pkg::C_SINE_ENTRIES,
    localparam int unsigned IdxW = $clog2(SINE_ENTRIES)
) (
    input  wire logic                    i_clk,
    input  wire logic [IdxW-1:0]         i_sin_idx,
    input  wire logic [IdxW-1:0]         i_cos_idx,
    output logic signed [15:0]           o_sin,
    output logic signed [15:0]           o_cos
);

    typedef logic signed [15:0] t_table [SINE_ENTRIES];

    // Taylor series through x^15/15! in Q30, mirrored per quadrant
    function automatic t_table f_build();
        t_table      tbl;
        logic [63:0] ph;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int unsigned k = 0; k < SINE_ENTRIES; k++) begin
            ph = (64'(k) << 32) / 64'(SINE_ENTRIES);
            r  = {34'd0, ph[29:0]};
            if (ph[30]) begin
                r = 64'h4000_0000 - r;
            end
            x = (r * focsv_pkg::C_HALF_PI_Q30) >> 30;
            t = x;
            s = x;
            for (int n = 1; n <= 7; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'(focsv_pkg::C_TAYLOR_DIV[n]);
                if (n[0]) begin
                    s = (s >= t) ? s - t : 64'd0;
                end else begin
                    s = s + t;
                end
            end
            v = (s * 64'd32767 + 64'h2000_0000) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tbl[k] = ph[31] ? -$signed(v[15:0]) : $signed(v[15:0]);
        end
        return tbl;
    endfunction

    localparam t_table C_TABLE = f_build();

    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    always_ff @(posedge i_clk) begin
        r_sin <= C_TABLE[i_sin_idx];
        r_cos <= C_TABLE[i_cos_idx];
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

### design/focsv_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reference frame transforms
// Clarke and Park on the currents, inverse Park with halving on the voltages.
// ----------------------------------------------------------------------------
module focsv_frame (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire focsv_pkg::t_ctl         i_ctl,
    input  wire logic signed [15:0]      i_phase_a_current,
    input  wire logic signed [15:0]      i_phase_b_current,
    input  wire logic signed [15:0]      i_phase_c_current,
    input  wire logic signed [15:0]      i_d_voltage,
    input  wire logic signed [15:0]      i_q_voltage,
    input  wire logic signed [15:0]      i_sin,
    input  wire logic signed [15:0]      i_cos,
    output focsv_pkg::t_ctl              o_ctl,
    output logic signed [16:0]           o_va,
    output logic signed [16:0]           o_vb,
    output logic signed [15:0]           o_d_current,
    output logic signed [15:0]           o_q_current
);

    focsv_pkg::t_ctl r_s1_ctl;
    focsv_pkg::t_ctl r_s2_ctl;
    focsv_pkg::t_ctl r_s3_ctl;

    // Stage 1: Clarke differences
    logic signed [17:0] n_s1_sa;
    logic signed [16:0] n_s1_sb;
    logic signed [17:0] r_s1_sa;
    logic signed [16:0] r_s1_sb;
    logic signed [15:0] r_s1_vd;
    logic signed [15:0] r_s1_vq;

    // Stage 2: Clarke and inverse Park products
    logic signed [32:0] r_s2_pa;
    logic signed [32:0] r_s2_pb;
    logic signed [31:0] r_s2_vdc;
    logic signed [31:0] r_s2_vqs;
    logic signed [31:0] r_s2_vqc;
    logic signed [31:0] r_s2_vds;
    logic signed [15:0] r_s2_sin;
    logic signed [15:0] r_s2_cos;

    // Stage 3: alpha/beta and halved voltages
    logic signed [39:0] alpha_full;
    logic signed [39:0] beta_full;
    logic signed [39:0] va_full;
    logic signed [39:0] vb_full;
    logic signed [16:0] r_s3_alpha;
    logic signed [16:0] r_s3_beta;
    logic signed [16:0] r_s3_va;
    logic signed [16:0] r_s3_vb;
    logic signed [15:0] r_s3_sin;
    logic signed [15:0] r_s3_cos;

    // Stage 4: Park products
    logic signed [32:0] r_s4_acs;
    logic signed [32:0] r_s4_bsn;
    logic signed [32:0] r_s4_bcs;
    logic signed [32:0] r_s4_asn;

    // Stage 5: rounded and saturated d/q
    logic signed [39:0] d_full;
    logic signed [39:0] q_full;
    logic signed [15:0] r_s5_d;
    logic signed [15:0] r_s5_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    assign n_s1_sa = (18'(i_phase_a_current) <<< 1) - 18'(i_phase_b_current)
                     - 18'(i_phase_c_current);
    assign n_s1_sb = 17'(i_phase_b_current) - 17'(i_phase_c_current);

    assign alpha_full = focsv_pkg::f_rnd(40'(r_s2_pa), 16);
    assign beta_full  = focsv_pkg::f_rnd(40'(r_s2_pb), 16);
    assign va_full    = focsv_pkg::f_rnd(40'(r_s2_vdc) - 40'(r_s2_vqs), 16);
    assign vb_full    = focsv_pkg::f_rnd(40'(r_s2_vqc) + 40'(r_s2_vds), 16);

    assign d_full = focsv_pkg::f_rnd(40'(r_s4_acs) + 40'(r_s4_bsn), 15);
    assign q_full = focsv_pkg::f_rnd(40'(r_s4_bcs) - 40'(r_s4_asn), 15);

    always_ff @(posedge i_clk) begin
        r_s1_sa  <= n_s1_sa;
        r_s1_sb  <= n_s1_sb;
        r_s1_vd  <= i_d_voltage;
        r_s1_vq  <= i_q_voltage;

        r_s2_pa  <= 33'(r_s1_sa) * 33'(focsv_pkg::C_K_THIRD);
        r_s2_pb  <= 33'(r_s1_sb) * 33'(focsv_pkg::C_K_INV_SQRT3);
        r_s2_vdc <= 32'(r_s1_vd) * 32'(i_cos);
        r_s2_vqs <= 32'(r_s1_vq) * 32'(i_sin);
        r_s2_vqc <= 32'(r_s1_vq) * 32'(i_cos);
        r_s2_vds <= 32'(r_s1_vd) * 32'(i_sin);
        r_s2_sin <= i_sin;
        r_s2_cos <= i_cos;

        r_s3_alpha <= alpha_full[16:0];
        r_s3_beta  <= beta_full[16:0];
        r_s3_va    <= va_full[16:0];
        r_s3_vb    <= vb_full[16:0];
        r_s3_sin   <= r_s2_sin;
        r_s3_cos   <= r_s2_cos;

        r_s4_acs <= 33'(r_s3_alpha) * 33'(r_s3_cos);
        r_s4_bsn <= 33'(r_s3_beta) * 33'(r_s3_sin);
        r_s4_bcs <= 33'(r_s3_beta) * 33'(r_s3_cos);
        r_s4_asn <= 33'(r_s3_alpha) * 33'(r_s3_sin);

        r_s5_d <= focsv_pkg::f_sat16(d_full);
        r_s5_q <= focsv_pkg::f_sat16(q_full);
    end

    assign o_ctl       = r_s3_ctl;
    assign o_va        = r_s3_va;
    assign o_vb        = r_s3_vb;
    assign o_d_current = r_s5_d;
    assign o_q_current = r_s5_q;

    // Clarke alpha never exceeds 4/3 of full scale
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_ctl.vld |-> (r_s3_alpha <= 17'sd43690 && r_s3_alpha >= -17'sd43690))
        else $error("alpha outside Clarke range");

endmodule
`default_nettype wire

### design/focsv_modulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Space vector modulator
// Three-phase references, min-max common-mode injection, saturated duties.
// ----------------------------------------------------------------------------
module focsv_modulator (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire focsv_pkg::t_ctl         i_ctl,
    input  wire logic signed [16:0]      i_va,
    input  wire logic signed [16:0]      i_vb,
    output focsv_pkg::t_ctl              o_ctl,
    output logic [15:0]                  o_duty_a,
    output logic [15:0]                  o_duty_b,
    output logic [15:0]                  o_duty_c
);

    // Duty = rnd(2x - m, 1) + one half, clamped to 0..1
    function automatic logic [15:0] f_duty(input logic signed [17:0] x,
                                           input logic signed [18:0] m);
        logic signed [19:0] e;
        logic signed [39:0] d;
        e = (20'(x) <<< 1) - 20'(m);
        d = focsv_pkg::f_rnd(40'(e), 1) + focsv_pkg::C_DUTY_MID;
        if (d < 40'sd0) begin
            f_duty = 16'h0000;
        end else if (d > 40'sd65535) begin
            f_duty = 16'hFFFF;
        end else begin
            f_duty = d[15:0];
        end
    endfunction

    focsv_pkg::t_ctl r_s4_ctl;
    focsv_pkg::t_ctl r_s5_ctl;
    focsv_pkg::t_ctl r_s6_ctl;
    focsv_pkg::t_ctl r_s7_ctl;

    logic signed [16:0] r_s4_va;
    logic signed [34:0] r_s4_tbp;

    logic signed [39:0] tb_full;
    logic signed [17:0] tb;
    logic signed [17:0] r_s5_a;
    logic signed [17:0] r_s5_b;
    logic signed [17:0] r_s5_c;

    logic signed [17:0] mx_ab;
    logic signed [17:0] mn_ab;
    logic signed [17:0] mx;
    logic signed [17:0] mn;
    logic signed [18:0] r_s6_m;
    logic signed [17:0] r_s6_a;
    logic signed [17:0] r_s6_b;
    logic signed [17:0] r_s6_c;

    logic [15:0] r_s7_duty_a;
    logic [15:0] r_s7_duty_b;
    logic [15:0] r_s7_duty_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
            r_s5_ctl <= '0;
            r_s6_ctl <= '0;
            r_s7_ctl <= '0;
        end else begin
            r_s4_ctl <= i_ctl;
            r_s5_ctl <= r_s4_ctl;
            r_s6_ctl <= r_s5_ctl;
            r_s7_ctl <= r_s6_ctl;
        end
    end

    assign tb_full = focsv_pkg::f_rnd(40'(r_s4_tbp), 15);
    assign tb      = tb_full[17:0];

    always_comb begin
        mx_ab = (r_s5_a > r_s5_b) ? r_s5_a : r_s5_b;
        mn_ab = (r_s5_a < r_s5_b) ? r_s5_a : r_s5_b;
        mx    = (r_s5_c > mx_ab) ? r_s5_c : mx_ab;
        mn    = (r_s5_c < mn_ab) ? r_s5_c : mn_ab;
    end

    always_ff @(posedge i_clk) begin
        r_s4_va  <= i_va;
        r_s4_tbp <= 35'(i_vb) * 35'(focsv_pkg::C_K_SQRT3_HALF);

        r_s5_a <= 18'(r_s4_va) <<< 1;
        r_s5_b <= tb - 18'(r_s4_va);
        r_s5_c <= -18'(r_s4_va) - tb;

        r_s6_m <= 19'(mx) + 19'(mn);
        r_s6_a <= r_s5_a;
        r_s6_b <= r_s5_b;
        r_s6_c <= r_s5_c;

        r_s7_duty_a <= f_duty(r_s6_a, r_s6_m);
        r_s7_duty_b <= f_duty(r_s6_b, r_s6_m);
        r_s7_duty_c <= f_duty(r_s6_c, r_s6_m);
    end

    assign o_ctl    = r_s7_ctl;
    assign o_duty_a = r_s7_duty_a;
    assign o_duty_b = r_s7_duty_b;
    assign o_duty_c = r_s7_duty_c;

    // The three phase references form a balanced set
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_ctl.vld |-> (20'(r_s5_a) + 20'(r_s5_b) + 20'(r_s5_c) == 20'sd0))
        else $error("phase references do not sum to zero");

endmodule
`default_nettype wire

### design/foc_transform_svpwm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FOC transform and SVPWM core
// Pipeline: the start edge reaches the o_valid strobe through one register stage
//   each for table read, Clarke products, rounding, Park products, d/q
//   rounding with phase references, min/max and duty clamp.
// Throughput: one transaction per cycle while busy is low; busy is high in reset
//   and until the first edge after it. Results are strobed once and cannot be held off.
// Reset: synchronous, clears the stage valid bits; the sine table is constant.
// ----------------------------------------------------------------------------
module foc_transform_svpwm_core #(
    parameter int unsigned SINE_ENTRIES = focsv_pkg::C_SINE_ENTRIES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_motor_id,
    input  wire logic [15:0]             i_rotor_angle,
    input  wire logic signed [15:0]      i_phase_a_current,
    input  wire logic signed [15:0]      i_phase_b_current,
    input  wire logic signed [15:0]      i_phase_c_current,
    input  wire logic signed [15:0]      i_d_voltage,
    input  wire logic signed [15:0]      i_q_voltage,
    output logic                         o_valid,
    output logic                         o_motor_tag,
    output logic signed [15:0]           o_d_current,
    output logic signed [15:0]           o_q_current,
    output logic [15:0]                  o_duty_a,
    output logic [15:0]                  o_duty_b,
    output logic [15:0]                  o_duty_c
);

    localparam int unsigned IdxW  = $clog2(SINE_ENTRIES);
    localparam int unsigned ProdW = 16 + IdxW;

    logic                   r_busy;
    logic                   accept;
    focsv_pkg::t_ctl        in_ctl;
    focsv_pkg::t_ctl        frame_ctl;
    focsv_pkg::t_ctl        mod_ctl;

    logic [15:0]            cos_angle;
    logic [ProdW-1:0]       sin_prod;
    logic [ProdW-1:0]       cos_prod;
    logic signed [15:0]     sin_val;
    logic signed [15:0]     cos_val;

    logic signed [16:0]     va;
    logic signed [16:0]     vb;
    logic signed [15:0]     d_cur;
    logic signed [15:0]     q_cur;
    logic signed [15:0]     r_s6_d;
    logic signed [15:0]     r_s6_q;
    logic signed [15:0]     r_s7_d;
    logic signed [15:0]     r_s7_q;

    // Hold off start until the first clock edge out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy       = r_busy;
    assign accept     = start & ~r_busy;
    assign in_ctl.vld = accept;
    assign in_ctl.tag = i_motor_id;

    // Table index is the angle scaled to the table length; cosine leads by a quarter turn
    assign cos_angle = i_rotor_angle + 16'd16384;
    assign sin_prod  = ProdW'(i_rotor_angle) * ProdW'(SINE_ENTRIES);
    assign cos_prod  = ProdW'(cos_angle) * ProdW'(SINE_ENTRIES);

    focsv_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_rom (
        .i_clk     (i_clk),
        .i_sin_idx (sin_prod[ProdW-1:16]),
        .i_cos_idx (cos_prod[ProdW-1:16]),
        .o_sin     (sin_val),
        .o_cos     (cos_val)
    );

    focsv_frame u_frame (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (in_ctl),
        .i_phase_a_current (i_phase_a_current),
        .i_phase_b_current (i_phase_b_current),
        .i_phase_c_current (i_phase_c_current),
        .i_d_voltage       (i_d_voltage),
        .i_q_voltage       (i_q_voltage),
        .i_sin             (sin_val),
        .i_cos             (cos_val),
        .o_ctl             (frame_ctl),
        .o_va              (va),
        .o_vb              (vb),
        .o_d_current       (d_cur),
        .o_q_current       (q_cur)
    );

    focsv_modulator u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (frame_ctl),
        .i_va     (va),
        .i_vb     (vb),
        .o_ctl    (mod_ctl),
        .o_duty_a (o_duty_a),
        .o_duty_b (o_duty_b),
        .o_duty_c (o_duty_c)
    );

    // Delay d/q to line up with the duties
    always_ff @(posedge i_clk) begin
        r_s6_d <= d_cur;
        r_s6_q <= q_cur;
        r_s7_d <= r_s6_d;
        r_s7_q <= r_s6_q;
    end

    assign o_valid     = mod_ctl.vld;
    assign o_motor_tag = mod_ctl.tag;
    assign o_d_current = r_s7_d;
    assign o_q_current = r_s7_q;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 7))
        else $error("result strobe without a transaction");

    a_tag_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 (o_motor_tag == $past(i_motor_id, 7)))
        else $error("motor tag does not match its transaction");

endmodule
`default_nettype wire
